@@ hdl/krf_pkg.sv @@
package krf_pkg;

   localparam int DEF_MAX_WIDTH = 1024;
   localparam int DEF_MAX_HALF  = 7;
   localparam int DEF_LINE_ROWS = 16;

   localparam int CSR_IW = 2;
   localparam int CSR_DW = 16;

   localparam logic [CSR_IW-1:0] CSR_HALF_WINDOW  = 2'd0;
   localparam logic [CSR_IW-1:0] CSR_IMAGE_WIDTH  = 2'd1;
   localparam logic [CSR_IW-1:0] CSR_IMAGE_HEIGHT = 2'd2;

   localparam logic CMD_PIXEL = 1'b0;
   localparam logic CMD_FLUSH = 1'b1;

   localparam logic [2:0]  RST_HALF_WINDOW  = 3'd1;
   localparam logic [10:0] RST_IMAGE_WIDTH  = 11'd640;
   localparam logic [15:0] RST_IMAGE_HEIGHT = 16'd480;

   typedef struct packed {
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
   } pixel_type;

   // largest usable half size: the window must fit in the line ring with a spare row
   function automatic int krf_half_limit(input int max_half, input int line_rows);
      int lim;
      lim = (line_rows - 2) / 2;
      return (max_half < lim) ? max_half : lim;
   endfunction

endpackage

@@ hdl/kuwahara_rgb_filter.sv @@
// Four-quadrant Kuwahara filter for an RGB raster stream.
// Input queue: push/full with req_cmd and the pixel colors; a flush word carries
// no pixel and lets pending output pixels out at the end of a frame.
// Output queue: empty/pop; the oldest filtered pixel sits on rsp_* while empty
// is low, rsp_frame_end marks the frame's last pixel.
// Configuration: csr_valid/csr_ready write channel (ready is always high);
// writing a register restarts the frame at pixel (0,0). Write only when idle.
// The front takes one word per cycle, writes each pixel word to the line ring and queues an
// output job when a window is complete. The back scans the window through the
// single read port of the line ring, one pixel per cycle, then runs the quadrant
// compares and, at default parameters, 14 divide steps. Input stalls while the job
// queue is full and at each row end until the back has drained, which keeps the ring
// safe to refill.
// A stalled output queue backs up into the back and then the front.
// Reset clears positions and restores half_window=1, 640x480; line ring
// contents are not cleared.
module kuwahara_rgb_filter import krf_pkg::*; #(
   parameter int MAX_WIDTH = DEF_MAX_WIDTH,
   parameter int MAX_HALF  = DEF_MAX_HALF,
   parameter int LINE_ROWS = DEF_LINE_ROWS
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  logic              req_cmd,
   input  logic [7:0]        req_red,
   input  logic [7:0]        req_green,
   input  logic [7:0]        req_blue,
   output logic              empty,
   input  logic              pop,
   output logic [7:0]        rsp_out_red,
   output logic [7:0]        rsp_out_green,
   output logic [7:0]        rsp_out_blue,
   output logic              rsp_frame_end,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [CSR_IW-1:0] csr_index,
   input  logic [CSR_DW-1:0] csr_data
);

   localparam int HLIM  = krf_half_limit(MAX_HALF, LINE_ROWS);
   localparam int HW    = $clog2(HLIM + 1);
   localparam int CW    = $clog2(MAX_WIDTH);
   localparam int SLW   = $clog2(LINE_ROWS);
   localparam int DEPTH = LINE_ROWS * MAX_WIDTH;
   localparam int AW    = $clog2(DEPTH);
   localparam int JW    = 16 + CW + SLW + 1;
   localparam int RW    = $bits(pixel_type) + 1;

   logic [2:0]  half_ff;
   logic [10:0] width_ff;
   logic [15:0] height_ff;

   logic [31:0]   w32, h32;
   logic [CW:0]   eff_w;
   logic [15:0]   eff_hgt;
   logic [HW-1:0] eff_h;
   logic          restart;

   logic           job_push, job_pop, job_full, job_empty, job_last, back_idle;
   logic [15:0]    job_row;
   logic [CW-1:0]  job_col;
   logic [SLW-1:0] job_slot;
   logic [JW-1:0]  job_rdata;
   logic [15:0]    bk_row;
   logic [CW-1:0]  bk_col;
   logic [SLW-1:0] bk_slot;
   logic           bk_last;

   logic           wr_en;
   logic [AW-1:0]  wr_addr, rd_addr;
   pixel_type      wr_data, rd_data, req_pix, res_pix, out_pix;
   logic           res_push, res_full, res_last, out_last;
   logic [RW-1:0]  res_rdata;

   assign csr_ready = 1'b1;
   assign restart   = csr_valid && ((csr_index == CSR_HALF_WINDOW) ||
                      (csr_index == CSR_IMAGE_WIDTH) || (csr_index == CSR_IMAGE_HEIGHT));

   always_ff @(posedge clock) begin
      if (reset) begin
         half_ff   <= RST_HALF_WINDOW;
         width_ff  <= RST_IMAGE_WIDTH;
         height_ff <= RST_IMAGE_HEIGHT;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_HALF_WINDOW:  half_ff   <= csr_data[2:0];
            CSR_IMAGE_WIDTH:  width_ff  <= csr_data[10:0];
            CSR_IMAGE_HEIGHT: height_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // zero size means one, oversize saturates
   always_comb begin
      w32 = (width_ff == '0) ? 32'd1 :
            ({21'd0, width_ff} > 32'(MAX_WIDTH)) ? 32'(MAX_WIDTH) : {21'd0, width_ff};
      h32 = ({29'd0, half_ff} > 32'(HLIM)) ? 32'(HLIM) : {29'd0, half_ff};
   end

   assign eff_w   = w32[CW:0];
   assign eff_h   = h32[HW-1:0];
   assign eff_hgt = (height_ff == '0) ? 16'd1 : height_ff;

   assign req_pix = '{blue: req_blue, green: req_green, red: req_red};

   krf_front #(
      .MAX_WIDTH(MAX_WIDTH), .MAX_HALF(MAX_HALF), .LINE_ROWS(LINE_ROWS)
   ) u_front (
      .clock(clock), .reset(reset), .push(push), .full(full), .cmd(req_cmd), .pix(req_pix),
      .eff_w(eff_w), .eff_hgt(eff_hgt), .eff_h(eff_h), .restart(restart),
      .back_idle(back_idle), .job_full(job_full), .job_empty(job_empty),
      .job_push(job_push), .job_row(job_row), .job_col(job_col), .job_slot(job_slot),
      .job_last(job_last), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data)
   );

   krf_fifo #(.WIDTH(JW), .DEPTH(2)) u_job_q (
      .clock(clock), .reset(reset), .push(job_push),
      .wdata({job_row, job_col, job_slot, job_last}), .full(job_full),
      .pop(job_pop), .rdata(job_rdata), .empty(job_empty)
   );

   assign {bk_row, bk_col, bk_slot, bk_last} = job_rdata;

   krf_ram #(.WIDTH($bits(pixel_type)), .DEPTH(DEPTH)) u_line_ram (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data)
   );

   krf_back #(
      .MAX_WIDTH(MAX_WIDTH), .MAX_HALF(MAX_HALF), .LINE_ROWS(LINE_ROWS)
   ) u_back (
      .clock(clock), .reset(reset), .eff_w(eff_w), .eff_hgt(eff_hgt), .eff_h(eff_h),
      .job_empty(job_empty), .job_pop(job_pop), .job_row(bk_row), .job_col(bk_col),
      .job_slot(bk_slot), .job_last(bk_last), .rd_addr(rd_addr), .rd_data(rd_data),
      .res_full(res_full), .res_push(res_push), .res_pix(res_pix), .res_last(res_last),
      .idle(back_idle)
   );

   krf_fifo #(.WIDTH(RW), .DEPTH(2)) u_res_q (
      .clock(clock), .reset(reset), .push(res_push), .wdata({res_pix, res_last}),
      .full(res_full), .pop(pop), .rdata(res_rdata), .empty(empty)
   );

   assign {out_pix, out_last} = res_rdata;
   assign rsp_out_red   = out_pix.red;
   assign rsp_out_green = out_pix.green;
   assign rsp_out_blue  = out_pix.blue;
   assign rsp_frame_end = out_last;

endmodule

@@ hdl/krf_ram.sv @@
module krf_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/krf_fifo.sv @@
module krf_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);

   localparam int PTW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTW-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [CNW-1:0]   count_ff;
   logic             do_push, do_pop;

   function automatic logic [PTW-1:0] ptr_inc(input logic [PTW-1:0] p);
      return (p == PTW'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign full    = (count_ff == CNW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            mem_ff[wr_ptr_ff] <= wdata;
            wr_ptr_ff         <= ptr_inc(wr_ptr_ff);
         end
         if (do_pop) begin
            rd_ptr_ff <= ptr_inc(rd_ptr_ff);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

@@ hdl/krf_front.sv @@
module krf_front import krf_pkg::*; #(
   parameter int MAX_WIDTH = DEF_MAX_WIDTH,
   parameter int MAX_HALF  = DEF_MAX_HALF,
   parameter int LINE_ROWS = DEF_LINE_ROWS
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      push,
   output logic                                      full,
   input  logic                                      cmd,
   input  pixel_type                                 pix,
   input  logic [$clog2(MAX_WIDTH):0]                eff_w,
   input  logic [15:0]                               eff_hgt,
   input  logic [$clog2(krf_half_limit(MAX_HALF, LINE_ROWS)+1)-1:0] eff_h,
   input  logic                                      restart,
   input  logic                                      back_idle,
   input  logic                                      job_full,
   input  logic                                      job_empty,
   output logic                                      job_push,
   output logic [15:0]                               job_row,
   output logic [$clog2(MAX_WIDTH)-1:0]              job_col,
   output logic [$clog2(LINE_ROWS)-1:0]              job_slot,
   output logic                                      job_last,
   output logic                                      wr_en,
   output logic [$clog2(LINE_ROWS*MAX_WIDTH)-1:0]    wr_addr,
   output pixel_type                                 wr_data
);

   localparam int CW  = $clog2(MAX_WIDTH);
   localparam int SLW = $clog2(LINE_ROWS);
   localparam int AW  = $clog2(LINE_ROWS * MAX_WIDTH);
   localparam int XS  = CW + 6;

   logic [15:0]    in_row_ff, in_row_in, out_row_ff, out_row_in;
   logic [CW-1:0]  in_col_ff, in_col_in, out_col_ff, out_col_in;
   logic [SLW-1:0] in_slot_ff, in_slot_in, out_slot_ff, out_slot_in;
   logic           drain_ff, drain_in;

   logic           accept, do_write, due, emit, out_col_wrap, out_row_wrap;
   logic [15:0]    in_row_w;
   logic [CW-1:0]  in_col_w;
   logic [SLW-1:0] in_slot_w;
   logic [16:0]    ry_sum;
   logic [15:0]    ry;
   logic [XS-1:0]  rx_sum;
   logic [CW-1:0]  rx;
   logic [CW:0]    w_m1;

   function automatic logic [SLW-1:0] slot_inc(input logic [SLW-1:0] s);
      return (s == SLW'(LINE_ROWS - 1)) ? '0 : s + 1'b1;
   endfunction

   assign full     = drain_ff || job_full;
   assign accept   = push && !full;
   assign do_write = accept && (cmd == CMD_PIXEL) && (in_row_ff < eff_hgt);
   assign w_m1     = eff_w - 1'b1;

   always_comb begin
      in_row_w  = in_row_ff;
      in_col_w  = in_col_ff;
      in_slot_w = in_slot_ff;
      if (do_write) begin
         if (({1'b0, in_col_ff} + 1'b1) >= eff_w) begin
            in_col_w  = '0;
            in_row_w  = in_row_ff + 16'd1;
            in_slot_w = slot_inc(in_slot_ff);
         end else begin
            in_col_w = in_col_ff + 1'b1;
         end
      end
   end

   // last pixel of the window, clamped to the image
   always_comb begin
      ry_sum = {1'b0, out_row_ff} + 17'(eff_h);
      ry     = (ry_sum >= {1'b0, eff_hgt}) ? eff_hgt - 16'd1 : ry_sum[15:0];
      rx_sum = XS'(out_col_ff) + XS'(eff_h);
      rx     = (rx_sum >= XS'(eff_w)) ? w_m1[CW-1:0] : rx_sum[CW-1:0];
   end

   assign due  = (out_row_ff < eff_hgt) &&
                 ((in_row_w > ry) || ((in_row_w == ry) && (in_col_w > rx)));
   assign emit = accept && due;

   assign out_col_wrap = ({1'b0, out_col_ff} + 1'b1) >= eff_w;
   assign out_row_wrap = ({1'b0, out_row_ff} + 17'd1) >= {1'b0, eff_hgt};

   assign job_push = emit;
   assign job_row  = out_row_ff;
   assign job_col  = out_col_ff;
   assign job_slot = out_slot_ff;
   assign job_last = (out_row_ff == eff_hgt - 16'd1) && ({1'b0, out_col_ff} == w_m1);

   assign wr_en   = do_write;
   assign wr_addr = AW'(in_slot_ff) * AW'(MAX_WIDTH) + AW'(in_col_ff);
   assign wr_data = pix;

   always_comb begin
      in_row_in   = in_row_w;
      in_col_in   = in_col_w;
      in_slot_in  = in_slot_w;
      out_row_in  = out_row_ff;
      out_col_in  = out_col_ff;
      out_slot_in = out_slot_ff;
      drain_in    = drain_ff;
      if (drain_ff && back_idle && job_empty) begin
         drain_in = 1'b0;
      end
      if (emit) begin
         if (out_col_wrap) begin
            // hold further input until the row's jobs are done with the line ring
            drain_in    = 1'b1;
            out_col_in  = '0;
            out_row_in  = out_row_ff + 16'd1;
            out_slot_in = slot_inc(out_slot_ff);
            if (out_row_wrap) begin
               in_row_in   = '0;
               in_col_in   = '0;
               in_slot_in  = '0;
               out_row_in  = '0;
               out_slot_in = '0;
            end
         end else begin
            out_col_in = out_col_ff + 1'b1;
         end
      end
      if (restart) begin
         in_row_in   = '0;
         in_col_in   = '0;
         in_slot_in  = '0;
         out_row_in  = '0;
         out_col_in  = '0;
         out_slot_in = '0;
         drain_in    = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_row_ff   <= '0;
         in_col_ff   <= '0;
         in_slot_ff  <= '0;
         out_row_ff  <= '0;
         out_col_ff  <= '0;
         out_slot_ff <= '0;
         drain_ff    <= 1'b0;
      end else begin
         in_row_ff   <= in_row_in;
         in_col_ff   <= in_col_in;
         in_slot_ff  <= in_slot_in;
         out_row_ff  <= out_row_in;
         out_col_ff  <= out_col_in;
         out_slot_ff <= out_slot_in;
         drain_ff    <= drain_in;
      end
   end

endmodule

@@ hdl/krf_back.sv @@
module krf_back import krf_pkg::*; #(
   parameter int MAX_WIDTH = DEF_MAX_WIDTH,
   parameter int MAX_HALF  = DEF_MAX_HALF,
   parameter int LINE_ROWS = DEF_LINE_ROWS
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic [$clog2(MAX_WIDTH):0]                eff_w,
   input  logic [15:0]                               eff_hgt,
   input  logic [$clog2(krf_half_limit(MAX_HALF, LINE_ROWS)+1)-1:0] eff_h,
   input  logic                                      job_empty,
   output logic                                      job_pop,
   input  logic [15:0]                               job_row,
   input  logic [$clog2(MAX_WIDTH)-1:0]              job_col,
   input  logic [$clog2(LINE_ROWS)-1:0]              job_slot,
   input  logic                                      job_last,
   output logic [$clog2(LINE_ROWS*MAX_WIDTH)-1:0]    rd_addr,
   input  pixel_type                                 rd_data,
   input  logic                                      res_full,
   output logic                                      res_push,
   output pixel_type                                 res_pix,
   output logic                                      res_last,
   output logic                                      idle
);

   localparam int HLIM = krf_half_limit(MAX_HALF, LINE_ROWS);
   localparam int HW   = $clog2(HLIM + 1);
   localparam int DW   = HW + 1;
   localparam int CW   = $clog2(MAX_WIDTH);
   localparam int SLW  = $clog2(LINE_ROWS);
   localparam int AW   = $clog2(LINE_ROWS * MAX_WIDTH);
   localparam int NMAX = (HLIM + 1) * (HLIM + 1);
   localparam int NW   = $clog2(NMAX + 1);
   localparam int SW   = $clog2(255 * NMAX + 1);
   localparam int QW   = $clog2(65025 * NMAX + 1);
   localparam int PW   = NW + QW;
   localparam int UW   = 2 * SW;
   localparam int VW   = PW + 2;
   localparam int NSW  = 2 * NW;
   localparam int LW   = VW + NSW;
   localparam int YW   = 17 + DW;
   localparam int XW   = CW + 1 + DW;
   localparam int SXW  = SLW + 1 + DW;
   localparam int CNW  = $clog2(SW);

   typedef enum logic [2:0] {
      S_IDLE, S_SCAN, S_WAIT, S_FIN, S_DIV, S_OUT
   } state_type;

   state_type state_ff;

   logic [15:0]          jrow_ff;
   logic [CW-1:0]        jcol_ff;
   logic [SLW-1:0]       jslot_ff;
   logic                 jlast_ff;
   logic signed [DW-1:0] dy_ff, dx_ff;
   logic                 rd_valid_ff;
   logic [3:0]           rd_quad_ff;

   logic [NW-1:0]  n_ff  [4];
   logic [SW-1:0]  s_ff  [4][3];
   logic [QW-1:0]  sq_ff [4][3];

   logic [1:0]     q_ff, fstep_ff, best_q_ff;
   logic [PW-1:0]  pt_ff [3];
   logic [UW-1:0]  pu_ff [3];
   logic [NSW-1:0] nsq_ff, best_nsq_ff;
   logic [VW-1:0]  v_ff, best_v_ff;
   logic [LW-1:0]  lhs_ff, rhs_ff;
   logic           have_ff;

   logic [SW-1:0]  dvd_ff [3];
   logic [SW-1:0]  quo_ff [3];
   logic [NW-1:0]  rem_ff [3];
   logic [NW-1:0]  dvs_ff;
   logic [CNW-1:0] dcnt_ff;

   logic signed [DW-1:0]  hs, neg_h;
   logic signed [YW-1:0]  yy;
   logic signed [XW-1:0]  xx;
   logic signed [SXW-1:0] sl_raw;
   logic [SLW-1:0]        sl_fix;
   logic                  pix_ok;
   logic [3:0]            quad;
   logic [7:0]            chan [3];
   logic [15:0]           sqv  [3];
   logic                  better;
   logic [1:0]            bq;
   logic [NW:0]           rem_sh [3];
   logic                  div_ge [3];
   logic [NW-1:0]         nsel;

   assign hs    = $signed({1'b0, eff_h});
   assign neg_h = -hs;

   // window position of the current scan point
   always_comb begin
      yy     = YW'($signed({1'b0, jrow_ff})) + YW'(dy_ff);
      xx     = XW'($signed({1'b0, jcol_ff})) + XW'(dx_ff);
      sl_raw = SXW'($signed({1'b0, jslot_ff})) + SXW'(dy_ff);
      if (sl_raw < 0) begin
         sl_raw = sl_raw + SXW'(LINE_ROWS);
      end else if (sl_raw >= SXW'(LINE_ROWS)) begin
         sl_raw = sl_raw - SXW'(LINE_ROWS);
      end
      sl_fix = sl_raw[SLW-1:0];
      pix_ok = (yy >= 0) && (yy < YW'($signed({1'b0, eff_hgt}))) &&
               (xx >= 0) && (xx < XW'($signed({1'b0, eff_w})));
      quad[0] = (dy_ff[DW-1] || dy_ff == '0) && (dx_ff[DW-1] || dx_ff == '0);
      quad[1] = (dy_ff[DW-1] || dy_ff == '0) && !dx_ff[DW-1];
      quad[2] = !dy_ff[DW-1] && (dx_ff[DW-1] || dx_ff == '0);
      quad[3] = !dy_ff[DW-1] && !dx_ff[DW-1];
   end

   assign rd_addr = AW'(sl_fix) * AW'(MAX_WIDTH) + AW'(xx[CW-1:0]);

   assign chan[0] = rd_data.red;
   assign chan[1] = rd_data.green;
   assign chan[2] = rd_data.blue;

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         sqv[c]    = 16'(chan[c]) * 16'(chan[c]);
         rem_sh[c] = {rem_ff[c], dvd_ff[c][SW-1]};
         div_ge[c] = rem_sh[c] >= {1'b0, dvs_ff};
      end
   end

   // variances compare as V_q * n_best^2 < V_best * n_q^2
   assign nsel   = n_ff[q_ff];
   assign better = (nsel != '0) && (!have_ff || (lhs_ff < rhs_ff));
   assign bq     = better ? q_ff : best_q_ff;

   assign idle     = (state_ff == S_IDLE);
   assign job_pop  = idle && !job_empty;
   assign res_push = (state_ff == S_OUT) && !res_full;
   assign res_pix  = '{blue: quo_ff[2][7:0], green: quo_ff[1][7:0], red: quo_ff[0][7:0]};
   assign res_last = jlast_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         rd_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= (state_ff == S_SCAN) && pix_ok;
         if (rd_valid_ff) begin
            for (int q = 0; q < 4; q++) begin
               if (rd_quad_ff[q]) begin
                  n_ff[q] <= n_ff[q] + 1'b1;
                  for (int c = 0; c < 3; c++) begin
                     s_ff[q][c]  <= s_ff[q][c] + SW'(chan[c]);
                     sq_ff[q][c] <= sq_ff[q][c] + QW'(sqv[c]);
                  end
               end
            end
         end
         unique case (state_ff)
            S_IDLE: begin
               if (!job_empty) begin
                  jrow_ff  <= job_row;
                  jcol_ff  <= job_col;
                  jslot_ff <= job_slot;
                  jlast_ff <= job_last;
                  dy_ff    <= neg_h;
                  dx_ff    <= neg_h;
                  have_ff  <= 1'b0;
                  q_ff     <= '0;
                  fstep_ff <= '0;
                  for (int q = 0; q < 4; q++) begin
                     n_ff[q] <= '0;
                     for (int c = 0; c < 3; c++) begin
                        s_ff[q][c]  <= '0;
                        sq_ff[q][c] <= '0;
                     end
                  end
                  state_ff <= S_SCAN;
               end
            end
            S_SCAN: begin
               rd_quad_ff <= quad;
               if (dx_ff == hs) begin
                  dx_ff <= neg_h;
                  if (dy_ff == hs) begin
                     state_ff <= S_WAIT;
                  end else begin
                     dy_ff <= dy_ff + DW'(1);
                  end
               end else begin
                  dx_ff <= dx_ff + DW'(1);
               end
            end
            S_WAIT: begin
               // last read still landing in the sums
               state_ff <= S_FIN;
            end
            S_FIN: begin
               fstep_ff <= fstep_ff + 1'b1;
               case (fstep_ff)
                  2'd0: begin
                     for (int c = 0; c < 3; c++) begin
                        pt_ff[c] <= PW'(nsel) * PW'(sq_ff[q_ff][c]);
                        pu_ff[c] <= UW'(s_ff[q_ff][c]) * UW'(s_ff[q_ff][c]);
                     end
                     nsq_ff <= NSW'(nsel) * NSW'(nsel);
                  end
                  2'd1: begin
                     v_ff <= (VW'(pt_ff[0]) - VW'(pu_ff[0])) + (VW'(pt_ff[1]) - VW'(pu_ff[1]))
                           + (VW'(pt_ff[2]) - VW'(pu_ff[2]));
                  end
                  2'd2: begin
                     lhs_ff <= LW'(v_ff) * LW'(best_nsq_ff);
                     rhs_ff <= LW'(best_v_ff) * LW'(nsq_ff);
                  end
                  default: begin
                     if (better) begin
                        have_ff     <= 1'b1;
                        best_v_ff   <= v_ff;
                        best_nsq_ff <= nsq_ff;
                        best_q_ff   <= q_ff;
                     end
                     if (q_ff == 2'd3) begin
                        for (int c = 0; c < 3; c++) begin
                           dvd_ff[c] <= s_ff[bq][c];
                           quo_ff[c] <= '0;
                           rem_ff[c] <= '0;
                        end
                        dvs_ff   <= n_ff[bq];
                        dcnt_ff  <= '0;
                        state_ff <= S_DIV;
                     end else begin
                        q_ff <= q_ff + 1'b1;
                     end
                  end
               endcase
            end
            S_DIV: begin
               // restoring division, one quotient bit per channel per cycle
               for (int c = 0; c < 3; c++) begin
                  rem_ff[c] <= div_ge[c] ? NW'(rem_sh[c] - {1'b0, dvs_ff}) : rem_sh[c][NW-1:0];
                  dvd_ff[c] <= dvd_ff[c] << 1;
                  quo_ff[c] <= {quo_ff[c][SW-2:0], div_ge[c]};
               end
               dcnt_ff <= dcnt_ff + 1'b1;
               if (dcnt_ff == CNW'(SW - 1)) begin
                  state_ff <= S_OUT;
               end
            end
            S_OUT: begin
               if (!res_full) begin
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule

@@ test/kuwahara_checker.sv @@
module kuwahara_checker import krf_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic              full,
   input  logic              req_cmd,
   input  logic [7:0]        req_red,
   input  logic [7:0]        req_green,
   input  logic [7:0]        req_blue,
   input  logic              empty,
   input  logic              pop,
   input  logic [7:0]        rsp_out_red,
   input  logic [7:0]        rsp_out_green,
   input  logic [7:0]        rsp_out_blue,
   input  logic              rsp_frame_end,
   input  logic              csr_valid,
   input  logic              csr_ready,
   input  logic [CSR_IW-1:0] csr_index,
   input  logic [CSR_DW-1:0] csr_data,
   output int                errors,
   output int                pending,
   output logic              frame_home
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RING_DEPTH = DEF_LINE_ROWS * DEF_MAX_WIDTH;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       frame_end;
   } filtered_pixel;

   pixel_type     ring [RING_DEPTH];
   logic [2:0]    half_reg;
   logic [10:0]   width_reg;
   logic [15:0]   height_reg;
   int            in_row, in_col, out_row, out_col;
   filtered_pixel filtered_q[$];

   assign frame_home = (in_row == 0) && (in_col == 0) && (out_row == 0) && (out_col == 0);

   function automatic int ring_slot(input int row, input int col);
      return ((row % DEF_LINE_ROWS) * DEF_MAX_WIDTH + col) % RING_DEPTH;
   endfunction

   task automatic filter_word(input logic cmd, input pixel_type px);
      int w, hgt, h, ry, rx, q, y0, y1, x0, x1, yy, xx, c;
      longint unsigned s[3], sq[3], n, v, best_v, best_n, val;
      logic [7:0] pick_mean[3];
      bit have;
      pixel_type p;
      filtered_pixel fp;
      w   = (width_reg == 0) ? 1 : (width_reg > DEF_MAX_WIDTH ? DEF_MAX_WIDTH : width_reg);
      hgt = (height_reg == 0) ? 1 : height_reg;
      h   = krf_half_limit(DEF_MAX_HALF, DEF_LINE_ROWS);
      if (half_reg < h) h = half_reg;
      if (cmd == CMD_PIXEL && in_row < hgt) begin
         ring[ring_slot(in_row, in_col)] = px;
         in_col++;
         if (in_col >= w) begin
            in_col = 0;
            in_row++;
         end
      end
      if (out_row >= hgt) return;
      ry = out_row + h; if (ry > hgt - 1) ry = hgt - 1;
      rx = out_col + h; if (rx > w - 1) rx = w - 1;
      if (in_row * w + in_col <= ry * w + rx) return;
      have = 0; best_v = 0; best_n = 1;
      pick_mean = '{8'd0, 8'd0, 8'd0};
      for (q = 0; q < 4; q++) begin
         y0 = (q < 2) ? -h : 0;      y1 = (q < 2) ? 0 : h;
         x0 = (q % 2) ? 0 : -h;      x1 = (q % 2) ? h : 0;
         s = '{0, 0, 0}; sq = '{0, 0, 0}; n = 0; v = 0;
         for (int dy = y0; dy <= y1; dy++) begin
            yy = out_row + dy;
            if (yy < 0 || yy >= hgt) continue;
            for (int dx = x0; dx <= x1; dx++) begin
               xx = out_col + dx;
               if (xx < 0 || xx >= w) continue;
               p = ring[ring_slot(yy, xx)];
               for (c = 0; c < 3; c++) begin
                  val = (c == 0) ? p.red : (c == 1) ? p.green : p.blue;
                  s[c] += val;
                  sq[c] += val * val;
               end
               n++;
            end
         end
         if (n == 0) continue;
         for (c = 0; c < 3; c++) v += n * sq[c] - s[c] * s[c];
         // strict compare: earlier quadrant keeps a tie
         if (!have || v * best_n * best_n < best_v * n * n) begin
            have = 1; best_v = v; best_n = n;
            for (c = 0; c < 3; c++) pick_mean[c] = 8'(s[c] / n);
         end
      end
      fp.red = pick_mean[0]; fp.green = pick_mean[1]; fp.blue = pick_mean[2];
      fp.frame_end = (out_row == hgt - 1) && (out_col == w - 1);
      filtered_q.push_back(fp);
      out_col++;
      if (out_col >= w) begin
         out_col = 0;
         out_row++;
         if (out_row >= hgt) begin
            in_row = 0; in_col = 0; out_row = 0; out_col = 0;
         end
      end
   endtask

   always @(posedge clock) begin
      filtered_pixel want;
      pixel_type px;
      if (reset) begin
         half_reg = RST_HALF_WINDOW;
         width_reg = RST_IMAGE_WIDTH;
         height_reg = RST_IMAGE_HEIGHT;
         in_row = 0; in_col = 0; out_row = 0; out_col = 0;
         filtered_q.delete();
         errors = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_HALF_WINDOW:  half_reg = csr_data[2:0];
               CSR_IMAGE_WIDTH:  width_reg = csr_data[10:0];
               CSR_IMAGE_HEIGHT: height_reg = csr_data[15:0];
               default: ;
            endcase
            if (csr_index inside {CSR_HALF_WINDOW, CSR_IMAGE_WIDTH, CSR_IMAGE_HEIGHT}) begin
               in_row = 0; in_col = 0; out_row = 0; out_col = 0;
            end
         end
         if (pop && !empty) begin
            if (filtered_q.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("unexpected output word r=%0d g=%0d b=%0d end=%0b",
                           rsp_out_red, rsp_out_green, rsp_out_blue, rsp_frame_end);
            end else begin
               want = filtered_q.pop_front();
               if (want.red !== rsp_out_red || want.green !== rsp_out_green ||
                   want.blue !== rsp_out_blue || want.frame_end !== rsp_frame_end) begin
                  errors++;
                  if (errors <= 10)
                     $display({"mismatch: expected r=%0d g=%0d b=%0d end=%0b,",
                               " got r=%0d g=%0d b=%0d end=%0b"},
                              want.red, want.green, want.blue, want.frame_end,
                              rsp_out_red, rsp_out_green, rsp_out_blue, rsp_frame_end);
               end
            end
         end
         if (push && !full) begin
            px.red = req_red; px.green = req_green; px.blue = req_blue;
            filter_word(req_cmd, px);
         end
      end
      pending = filtered_q.size();
   end
endmodule

@@ test/testbench.sv @@
module testbench import krf_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [CSR_IW-1:0] CSR_SPARE = 2'd3;
   localparam int STALL_LIMIT = 20000;
   localparam int SETTLE = 400;   // settle wait for the back's last job at the largest window

   logic              clock = 0;
   logic              reset = 1;
   logic              push = 0;
   logic              full;
   logic              req_cmd = 0;
   logic [7:0]        req_red = 0, req_green = 0, req_blue = 0;
   logic              empty;
   logic              pop = 0;
   logic [7:0]        rsp_out_red, rsp_out_green, rsp_out_blue;
   logic              rsp_frame_end;
   logic              csr_valid = 0;
   logic              csr_ready;
   logic [CSR_IW-1:0] csr_index = 0;
   logic [CSR_DW-1:0] csr_data = 0;
   int                errors, pending;
   logic              frame_home;
   int                words_sent = 0;
   int                idle_mode = 0;   // 0: sender 22 / receiver 49, 1: swapped, 2: none
   bit                hold_off = 0;
   int                quiet = 0;

   always #6 clock = ~clock;

   kuwahara_rgb_filter dut (.*);

   kuwahara_checker u_checker (.*);

   always @(posedge clock) begin
      if ((push && !full) || (pop && !empty) || (csr_valid && csr_ready) || reset)
         quiet <= 0;
      else
         quiet <= quiet + 1;
      if (quiet >= STALL_LIMIT) begin
         $display("testbench NOT OK");
         $finish;
      end
   end

   // receiver
   initial begin
      int pct;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_off) begin
            pop <= 0;
            repeat (600) @(posedge clock);
            hold_off = 0;
         end
         pct = (idle_mode == 0) ? 49 : (idle_mode == 1) ? 22 : 0;
         pop <= ($urandom_range(0, 99) >= pct);
      end
   end

   task automatic send_word(input logic cmd, input logic [7:0] r, g, b);
      int pct;
      pct = (idle_mode == 0) ? 22 : (idle_mode == 1) ? 49 : 0;
      if ($urandom_range(0, 99) < pct) begin
         push <= 0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      push <= 1;
      req_cmd <= cmd; req_red <= r; req_green <= g; req_blue <= b;
      @(posedge clock);
      while (full) @(posedge clock);
      words_sent++;
      idle_mode = (words_sent < 320) ? 0 : (words_sent < 640) ? 1 : 2;
   endtask

   task automatic send_random_pixel();
      send_word(CMD_PIXEL, 8'($urandom), 8'($urandom), 8'($urandom));
   endtask

   task automatic send_random_flush();
      send_word(CMD_FLUSH, 8'($urandom), 8'($urandom), 8'($urandom));
   endtask

   // waits for a drained block, then programs a new frame shape
   task automatic set_frame(input int half, input int width, input int height);
      push <= 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      csr_valid <= 1;
      csr_index <= CSR_SPARE; csr_data <= CSR_DW'($urandom);
      @(posedge clock); while (!csr_ready) @(posedge clock);
      csr_index <= CSR_HALF_WINDOW; csr_data <= CSR_DW'(half);
      @(posedge clock); while (!csr_ready) @(posedge clock);
      csr_index <= CSR_IMAGE_WIDTH; csr_data <= CSR_DW'(width);
      @(posedge clock); while (!csr_ready) @(posedge clock);
      csr_index <= CSR_IMAGE_HEIGHT; csr_data <= CSR_DW'(height);
      @(posedge clock); while (!csr_ready) @(posedge clock);
      csr_valid <= 0;
   endtask

   // pixels of one frame with some flush words mixed in, then drain the tail
   task automatic run_frame(input int half, input int width, input int height);
      int npix, done;
      set_frame(half, width, height);
      npix = ((width == 0) ? 1 : (width > 1024 ? 1024 : width)) * ((height == 0) ? 1 : height);
      done = 0;
      while (done < npix) begin
         if ($urandom_range(0, 9) == 0) send_random_flush();
         else begin
            send_random_pixel();
            done++;
         end
      end
      // pixels here are dropped by the block until the frame's last output job is queued
      while (!frame_home) begin
         if ($urandom_range(0, 9) < 3) send_random_pixel();
         else send_random_flush();
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // default shape: nothing completes within a few words
      repeat (4) send_random_pixel();
      send_word(CMD_FLUSH, 8'hff, 8'hff, 8'hff);

      // zero half size: output equals input
      set_frame(0, 2, 2);
      send_word(CMD_PIXEL, 8'h00, 8'h00, 8'h00);
      send_word(CMD_PIXEL, 8'hff, 8'hff, 8'hff);
      send_word(CMD_FLUSH, 8'h00, 8'h00, 8'h00);
      send_word(CMD_PIXEL, 8'hff, 8'h00, 8'hff);
      send_word(CMD_PIXEL, 8'h00, 8'hff, 8'h00);
      while (!frame_home) send_word(CMD_FLUSH, 8'h00, 8'h00, 8'h00);

      // flat image: all quadrants tie
      set_frame(7, 3, 3);
      repeat (9) send_word(CMD_PIXEL, 8'h80, 8'h80, 8'h80);
      while (!frame_home) send_word(CMD_FLUSH, 8'h00, 8'h00, 8'h00);

      // zero sizes count as one
      run_frame(1, 0, 0);

      // oversized width saturates; long receiver hold-off while the row streams in
      set_frame(3, 2047, 1);
      hold_off = 1;
      repeat (1024) send_random_pixel();
      while (!frame_home) send_word(CMD_FLUSH, 8'h00, 8'h00, 8'h00);

      // tallest frame, only partly sent before the next setup
      set_frame(2, 1, 65535);
      repeat (12) send_random_pixel();

      while (words_sent < 1100)
         run_frame($urandom_range(0, 7), $urandom_range(1, 12), $urandom_range(1, 8));

      push <= 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      if (errors == 0 && pending == 0)
         $display("testbench OK");
      else
         $display("testbench NOT OK");
      $finish;
   end
endmodule
